[rtl/smgd_pkg.sv]
`default_nettype none

package smgd_pkg;

    localparam int GRID_SIDE  = 7;
    localparam int INNER_SIDE = 5;
    localparam int GRID_W     = GRID_SIDE * GRID_SIDE;
    localparam int INNER_W    = INNER_SIDE * INNER_SIDE;
    localparam int ROT_N      = 4;
    localparam int CODE_N     = 4;
    localparam int ROW_DIST_W = 3;
    localparam int DIST_W     = 5;
    localparam int ID_W       = 10;
    localparam int ROT_W      = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_VALID  = 2'd0,
        STATUS_BORDER = 2'd1,
        STATUS_CODE   = 2'd2
    } status_t;

    // Code words as column masks: bit x is column x.
    localparam logic [INNER_SIDE-1:0] CODE_WORDS [CODE_N] = '{
        5'h01, 5'h1D, 5'h12, 5'h0E
    };

    typedef logic [INNER_W-1:0]                         inner_bits_t;
    typedef logic [ROT_N-1:0][INNER_SIDE-1:0][ROW_DIST_W-1:0] row_dist_t;
    typedef logic [ROT_N-1:0][DIST_W-1:0]               rot_total_t;

    // Stage 1 -> stage 2
    typedef struct packed {
        logic        valid;
        logic        border;
        inner_bits_t inner;
        row_dist_t   row_dist;
    } score_t;

    // Stage 2 -> stage 3
    typedef struct packed {
        logic        valid;
        logic        border;
        inner_bits_t inner;
        rot_total_t  total;
    } total_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   marker_id;
        logic [ROT_W-1:0]  rotation;
        logic [DIST_W-1:0] code_distance;
    } result_t;

    function automatic logic [GRID_W-1:0] make_border_mask();
        logic [GRID_W-1:0] m;
        m = '0;
        for (int r = 0; r < GRID_SIDE; r++)
        begin
            for (int c = 0; c < GRID_SIDE; c++)
            begin
                if (r == 0 || r == GRID_SIDE - 1 || c == 0 || c == GRID_SIDE - 1)
                begin
                    m[r*GRID_SIDE + c] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    localparam logic [GRID_W-1:0] BORDER_MASK = make_border_mask();

    // One quarter turn: b'(y,x) = b(4-x, y). Pure wiring.
    function automatic inner_bits_t rot_quarter(input inner_bits_t b);
        inner_bits_t q;
        for (int y = 0; y < INNER_SIDE; y++)
        begin
            for (int x = 0; x < INNER_SIDE; x++)
            begin
                q[y*INNER_SIDE + x] = b[(INNER_SIDE - 1 - x)*INNER_SIDE + y];
            end
        end
        return q;
    endfunction

    function automatic logic [ROW_DIST_W-1:0] popcount5(input logic [INNER_SIDE-1:0] v);
        logic [ROW_DIST_W-1:0] n;
        n = '0;
        for (int i = 0; i < INNER_SIDE; i++)
        begin
            n = n + ROW_DIST_W'(v[i]);
        end
        return n;
    endfunction

    // Least Hamming distance of one row to the code words.
    function automatic logic [ROW_DIST_W-1:0] row_min_dist(input logic [INNER_SIDE-1:0] row);
        logic [ROW_DIST_W-1:0] best;
        logic [ROW_DIST_W-1:0] d;
        best = ROW_DIST_W'(INNER_SIDE);
        for (int p = 0; p < CODE_N; p++)
        begin
            d = popcount5(row ^ CODE_WORDS[p]);
            if (d < best)
            begin
                best = d;
            end
        end
        return best;
    endfunction

endpackage

`default_nettype wire

[rtl/smgd_if.sv]
`default_nettype none

interface smgd_grid_if;
    import smgd_pkg::*;

    logic              valid;
    logic              ready;
    logic [GRID_W-1:0] cell_grid;

    modport source (output valid, output cell_grid, input ready);
    modport sink   (input valid, input cell_grid, output ready);
endinterface

interface smgd_result_if;
    import smgd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     marker_id;
    logic [ROT_W-1:0]    rotation;
    logic [DIST_W-1:0]   code_distance;

    modport source (output valid, output status, output marker_id, output rotation,
                    output code_distance, input ready);
    modport sink   (input valid, input status, input marker_id, input rotation,
                    input code_distance, output ready);
endinterface

`default_nettype wire

[rtl/square_marker_grid_decode_core.sv]
// Square fiducial marker decoder for 7x7 cell grids (5x5 inner code).
//
// Channels: "grid" takes one 49-bit cell grid per transfer (bit r*7+c is
// row r, column c, 1 = white). "result" returns one transfer per grid with
// status, marker_id, rotation and code_distance. Both use valid/ready; a
// transfer happens on a rising edge with valid and ready high.
//
// Pipeline: three register stages (row scoring of all four orientations,
// per-orientation sums, best-orientation pick and id extraction). A grid
// passes through the score, sum and pick registers in that order to result
// valid; throughput is one grid per cycle while result.ready is high, as
// each stage takes a new item whenever it moves on.
//
// Stall: when result.ready is low the last stage holds its result; each
// earlier stage keeps accepting until it is itself full, so up to three
// grids sit in flight. Nothing is dropped or repeated.
//
// Reset: rst_n is asynchronous and clears all stage valid bits; the block
// accepts a grid in the first cycle after reset is released.
`default_nettype none

module square_marker_grid_decode_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    smgd_grid_if.sink     grid,
    smgd_result_if.source result
);
    import smgd_pkg::*;

    score_t  score_stage;
    total_t  total_stage;
    result_t pick_result;
    logic    sum_in_ready;
    logic    pick_in_ready;

    // Stage 1: border check, inner bits, per-row distances for four turns.
    smgd_score_stage u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (grid.valid),
        .in_grid   (grid.cell_grid),
        .in_ready  (grid.ready),
        .out_stage (score_stage),
        .out_ready (sum_in_ready)
    );

    // Stage 2: sum the five row distances of each orientation.
    smgd_sum_stage u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stage  (score_stage),
        .in_ready  (sum_in_ready),
        .out_stage (total_stage),
        .out_ready (pick_in_ready)
    );

    // Stage 3: pick the first least total, build the result word.
    smgd_pick_stage u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stage   (total_stage),
        .in_ready   (pick_in_ready),
        .out_valid  (result.valid),
        .out_result (pick_result),
        .out_ready  (result.ready)
    );

    assign result.status        = pick_result.status;
    assign result.marker_id     = pick_result.marker_id;
    assign result.rotation      = pick_result.rotation;
    assign result.code_distance = pick_result.code_distance;

    // A border failure carries no rotation and no distance.
    a_border_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == STATUS_BORDER
        |-> result.rotation == '0 && result.code_distance == '0 && result.marker_id == '0)
        else $error("border failure with nonzero fields");

    // A valid marker always has zero distance.
    a_valid_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == STATUS_VALID |-> result.code_distance == '0)
        else $error("valid marker with nonzero distance");

    // A code failure has a nonzero distance and no id.
    a_code_fail: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == STATUS_CODE
        |-> result.code_distance != '0 && result.marker_id == '0)
        else $error("code failure fields inconsistent");

    // With the output always drained, a grid shows up after the score, sum and pick stages.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        grid.valid && grid.ready && result.ready ##1 result.ready ##1 result.ready
        |=> result.valid)
        else $error("result missing three cycles after transfer");

endmodule

`default_nettype wire

[rtl/smgd_score_stage.sv]
`default_nettype none

module smgd_score_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [smgd_pkg::GRID_W-1:0] in_grid,
    output logic                             in_ready,
    output smgd_pkg::score_t                 out_stage,
    input  wire logic                        out_ready
);
    import smgd_pkg::*;

    score_t      stage_reg;
    score_t      stage_next;
    inner_bits_t rot_bits [ROT_N];
    logic        advance;

    assign advance  = !stage_reg.valid || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        stage_next        = stage_reg;
        stage_next.valid  = in_valid;
        stage_next.border = |(in_grid & BORDER_MASK);
        for (int r = 0; r < INNER_SIDE; r++)
        begin
            for (int c = 0; c < INNER_SIDE; c++)
            begin
                stage_next.inner[r*INNER_SIDE + c] = in_grid[(r + 1)*GRID_SIDE + c + 1];
            end
        end
        rot_bits[0] = stage_next.inner;
        for (int k = 1; k < ROT_N; k++)
        begin
            rot_bits[k] = rot_quarter(rot_bits[k-1]);
        end
        // Score every row of every orientation in parallel.
        for (int k = 0; k < ROT_N; k++)
        begin
            for (int y = 0; y < INNER_SIDE; y++)
            begin
                stage_next.row_dist[k][y] = row_min_dist(rot_bits[k][y*INNER_SIDE +: INNER_SIDE]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_stage = stage_reg;

endmodule

`default_nettype wire

[rtl/smgd_sum_stage.sv]
`default_nettype none

module smgd_sum_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire smgd_pkg::score_t in_stage,
    output logic                  in_ready,
    output smgd_pkg::total_t      out_stage,
    input  wire logic             out_ready
);
    import smgd_pkg::*;

    total_t stage_reg;
    total_t stage_next;
    logic   advance;

    assign advance  = !stage_reg.valid || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        stage_next        = stage_reg;
        stage_next.valid  = in_stage.valid;
        stage_next.border = in_stage.border;
        stage_next.inner  = in_stage.inner;
        for (int k = 0; k < ROT_N; k++)
        begin
            stage_next.total[k] = '0;
            for (int y = 0; y < INNER_SIDE; y++)
            begin
                stage_next.total[k] = stage_next.total[k] + DIST_W'(in_stage.row_dist[k][y]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_stage = stage_reg;

endmodule

`default_nettype wire

[rtl/smgd_pick_stage.sv]
`default_nettype none

module smgd_pick_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire smgd_pkg::total_t in_stage,
    output logic                  in_ready,
    output logic                  out_valid,
    output smgd_pkg::result_t     out_result,
    input  wire logic             out_ready
);
    import smgd_pkg::*;

    logic              valid_reg;
    result_t           result_reg;
    result_t           result_next;
    logic [ROT_W-1:0]  best_rot;
    logic [DIST_W-1:0] best_dist;
    inner_bits_t       rot_bits [ROT_N];
    inner_bits_t       best_bits;
    logic              advance;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        rot_bits[0] = in_stage.inner;
        for (int k = 1; k < ROT_N; k++)
        begin
            rot_bits[k] = rot_quarter(rot_bits[k-1]);
        end

        // Strict compare keeps the lowest rotation on a tie.
        best_rot  = '0;
        best_dist = in_stage.total[0];
        for (int k = 1; k < ROT_N; k++)
        begin
            if (in_stage.total[k] < best_dist)
            begin
                best_dist = in_stage.total[k];
                best_rot  = ROT_W'(k);
            end
        end
        best_bits = rot_bits[best_rot];

        result_next = '0;
        if (in_stage.border)
        begin
            result_next.status = STATUS_BORDER;
        end
        else if (best_dist != '0)
        begin
            result_next.status        = STATUS_CODE;
            result_next.rotation      = best_rot;
            result_next.code_distance = best_dist;
        end
        else
        begin
            result_next.status   = STATUS_VALID;
            result_next.rotation = best_rot;
            // Columns 1 and 3 of each row, top row most significant.
            for (int r = 0; r < INNER_SIDE; r++)
            begin
                result_next.marker_id[ID_W-1-2*r] = best_bits[r*INNER_SIDE + 1];
                result_next.marker_id[ID_W-2-2*r] = best_bits[r*INNER_SIDE + 3];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire
